// ===== hdl/lcc_pkg.sv =====
// ----------------------------------------------------------------------------
// lcc_pkg: shared types and constants for the Luhn card number classifier
// Controller states, command and status bundles, field widths and type codes.
// ----------------------------------------------------------------------------
package lcc_pkg;

    localparam int NUM_BITS   = 63;              // binary input width
    localparam int NUM_DIGITS = 19;              // decimal digits a 63-bit value can need
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = 6;               // counts conversion bits and digit slots
    localparam int MAX_DIGITS = 19;              // longest number that may get a type
    localparam int IDX_W      = 5;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 8;

    localparam logic [1:0] CARD_INVALID = 2'd0;
    localparam logic [1:0] CARD_TYPE_A  = 2'd1;  // fifteen digits, prefix 34 or 37
    localparam logic [1:0] CARD_TYPE_B  = 2'd2;  // thirteen or sixteen digits, leading 4
    localparam logic [1:0] CARD_TYPE_C  = 2'd3;  // sixteen digits, prefix 51 to 55

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_DONE
    } lcc_state_t;

    typedef struct packed {
        logic load;
        logic conv;
        logic scan;
        logic finish;
    } lcc_cmd_t;

    typedef struct packed {
        logic conv_last;
        logic scan_last;
        logic out_free;
    } lcc_status_t;

endpackage

// ===== hdl/lcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcc_ctrl: sequencer for the Luhn card number classifier
// Steps the datapath through load, binary-to-decimal conversion, digit scan
// and result hand-over.
// ----------------------------------------------------------------------------
module lcc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  lcc_pkg::lcc_status_t status,
    output lcc_pkg::lcc_cmd_t    cmd
);
    import lcc_pkg::*;

    lcc_state_t state_reg;
    lcc_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (status.conv_last) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (status.scan_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_CONV: begin
                cmd.conv = 1'b1;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
            end
            ST_DONE: begin
                cmd.finish = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hdl/lcc_datapath.sv =====
// ----------------------------------------------------------------------------
// lcc_datapath: conversion, digit scan and result register
// Shift-and-add-3 conversion one bit a cycle, then one decimal digit a cycle
// for length, leading digits and the running Luhn sum modulo ten.
// ----------------------------------------------------------------------------
module lcc_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [lcc_pkg::NUM_BITS-1:0]    card_number,
    input  lcc_pkg::lcc_cmd_t               cmd,
    output lcc_pkg::lcc_status_t            status,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lcc_pkg::OUT_DATA_W-1:0]  m_tdata
);
    import lcc_pkg::*;

    logic [NUM_BITS-1:0] bin_reg,    bin_next;
    logic [BCD_W-1:0]    bcd_reg,    bcd_next;
    logic [BCD_W-1:0]    bcd_adj;
    logic [CNT_W-1:0]    cnt_reg,    cnt_next;
    logic [3:0]          sum_reg,    sum_next;
    logic [4:0]          count_reg,  count_next;
    logic [3:0]          first_reg,  first_next;
    logic [3:0]          second_reg, second_next;
    logic [3:0]          prev_reg,   prev_next;
    logic                valid_reg,  valid_next;
    logic [1:0]          type_reg,   type_next;
    logic                ok_reg,     ok_next;
    logic [4:0]          dcount_reg, dcount_next;

    logic [IDX_W-1:0]    idx;
    logic [3:0]          digit;
    logic [4:0]          dbl;
    logic [3:0]          luhn_d;
    logic [4:0]          acc;
    logic                ok;
    logic [1:0]          card_type;

    assign idx   = cnt_reg[IDX_W-1:0];
    assign digit = bcd_reg[3:0];

    // add 3 to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // double digits in odd slots, counting the lowest as slot zero
    always_comb begin
        dbl = {digit, 1'b0};
        if (!idx[0]) begin
            luhn_d = digit;
        end else if (dbl > 5'd9) begin
            luhn_d = 4'(dbl - 5'd9);
        end else begin
            luhn_d = dbl[3:0];
        end
        acc = {1'b0, sum_reg} + {1'b0, luhn_d};
    end

    assign ok = (sum_reg == 4'd0);

    always_comb begin
        card_type = CARD_INVALID;
        if (ok && (count_reg <= 5'(MAX_DIGITS))) begin
            if (count_reg == 5'd15 && first_reg == 4'd3 &&
                (second_reg == 4'd4 || second_reg == 4'd7)) begin
                card_type = CARD_TYPE_A;
            end else if ((count_reg == 5'd13 || count_reg == 5'd16) &&
                         first_reg == 4'd4) begin
                card_type = CARD_TYPE_B;
            end else if (count_reg == 5'd16 && first_reg == 4'd5 &&
                         second_reg >= 4'd1 && second_reg <= 4'd5) begin
                card_type = CARD_TYPE_C;
            end
        end
    end

    always_comb begin
        bin_next    = bin_reg;
        bcd_next    = bcd_reg;
        cnt_next    = cnt_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        first_next  = first_reg;
        second_next = second_reg;
        prev_next   = prev_reg;
        valid_next  = valid_reg && !m_tready;
        type_next   = type_reg;
        ok_next     = ok_reg;
        dcount_next = dcount_reg;

        if (cmd.load) begin
            bin_next    = card_number;
            bcd_next    = '0;
            cnt_next    = '0;
            sum_next    = '0;
            count_next  = 5'd1;
            first_next  = '0;
            second_next = '0;
            prev_next   = '0;
        end
        if (cmd.conv) begin
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[NUM_BITS-1]};
            bin_next = {bin_reg[NUM_BITS-2:0], 1'b0};
            cnt_next = status.conv_last ? '0 : cnt_reg + 1'b1;
        end
        if (cmd.scan) begin
            // advance to the next digit up
            bcd_next = {4'd0, bcd_reg[BCD_W-1:4]};
            cnt_next = cnt_reg + 1'b1;
            sum_next = (acc >= 5'd10) ? 4'(acc - 5'd10) : acc[3:0];
            prev_next = digit;
            if (digit != 4'd0) begin
                count_next  = 5'(idx) + 5'd1;
                first_next  = digit;
                second_next = prev_reg;
            end
        end
        if (cmd.finish) begin
            valid_next  = 1'b1;
            type_next   = card_type;
            ok_next     = ok;
            dcount_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg    <= bin_next;
        bcd_reg    <= bcd_next;
        cnt_reg    <= cnt_next;
        sum_reg    <= sum_next;
        count_reg  <= count_next;
        first_reg  <= first_next;
        second_reg <= second_next;
        prev_reg   <= prev_next;
        type_reg   <= type_next;
        ok_reg     <= ok_next;
        dcount_reg <= dcount_next;
    end

    assign status.conv_last = (cnt_reg == CNT_W'(NUM_BITS - 1));
    assign status.scan_last = (cnt_reg == CNT_W'(NUM_DIGITS - 1));
    assign status.out_free  = !valid_reg || m_tready;

    assign m_tvalid = valid_reg;
    assign m_tdata  = {dcount_reg, ok_reg, type_reg};

endmodule

// ===== hdl/luhn_card_number_classifier_core.sv =====
// ----------------------------------------------------------------------------
// luhn_card_number_classifier_core: Luhn mod-10 check and card classification
// Streaming top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Each accepted word carries one 63-bit unsigned card number and yields one
// result word. The number is converted to decimal one bit a cycle by a
// shift-and-add-3 register, then the 19 decimal digits are walked one a cycle
// from the lowest, building the digit count, the two leading digits and the
// Luhn sum modulo ten. The result is then loaded into the output register once
// that register is free. The next word is taken as soon as the result sits in
// the output register, even if the downstream side has not yet taken it. A
// failed checksum always reports card type 0; the number zero counts as one
// digit.
module luhn_card_number_classifier_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lcc_pkg::IN_DATA_W-1:0]     s_tdata,   // [62:0] card_number
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lcc_pkg::OUT_DATA_W-1:0]    m_tdata    // [1:0] card_type, [2] checksum_ok,
                                                         // [7:3] digit_count
);
    import lcc_pkg::*;

    lcc_cmd_t    cmd;
    lcc_status_t status;

    lcc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lcc_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .card_number (s_tdata[NUM_BITS-1:0]),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // busy straight after a word is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while conversion running");

    // a typed card always passed the checksum
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] != CARD_INVALID) |-> m_tdata[2])
        else $error("card type given with failed checksum");

    // the fifteen-digit type only with fifteen digits
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] == CARD_TYPE_A) |-> (m_tdata[7:3] == 5'd15))
        else $error("type A with wrong length");

    // digit count stays within one to nineteen
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:3] != 5'd0 && m_tdata[7:3] <= 5'(NUM_DIGITS)))
        else $error("digit count out of range");

endmodule
